// ===== design/kei_pkg.sv =====
// ----------------------------------------------------------------------------
// kei_pkg
// Shared types, codes and constants of the keyframe envelope interpolator.
// ----------------------------------------------------------------------------
package kei_pkg;

  localparam int unsigned MAX_KEYFRAMES_DEF    = 64;
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;

  localparam logic [15:0] SCALE_RESET = 16'd256;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // divisors (2k)(2k+1) of the sine series terms
  localparam int unsigned SERIES_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        [1:0]  command;
    logic        [15:0] key_position;
    logic signed [15:0] key_value;
    logic        [23:0] query_position;
  } req_t;

  typedef struct packed {
    logic signed [15:0] eased_value;
    logic        [1:0]  status;
    logic        [6:0]  keyframe_count;
  } rsp_t;

  typedef struct packed {
    logic        [15:0] pos;
    logic signed [15:0] val;
  } kf_t;

endpackage

// ===== design/kei_stream_if.sv =====
// ----------------------------------------------------------------------------
// kei_stream_if
// Valid/ready channel carrying one request or result payload.
// ----------------------------------------------------------------------------
interface kei_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/keyframe_envelope_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_envelope_interpolator
// Sorted keyframe table with insert, clear and sine-eased query.
// ----------------------------------------------------------------------------
// One request is handled at a time; a finished result waits in the output
// register while the next request is taken. Clear, undefined commands, a
// full insert and an empty query go straight to the finish state. An insert
// moves each stored key above its place one entry up (read, then write),
// from the top down, then writes the new key; on an empty table it writes
// the key at once. A query reads each memory entry it touches, multiplies
// its position by the scale and compares: the first key (whose value is the
// result at or below it), then the last (likewise at or above it), then every
// key for the bracketing pair. When the bracketing span or value step is
// zero the lower value is returned; otherwise a restoring divider forms the
// sine index, followed by the table read, multiply and rounding. A request
// leaves the finish state only when the output register is free or being
// read. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module keyframe_envelope_interpolator #(
  parameter int unsigned MAX_KEYFRAMES    = kei_pkg::MAX_KEYFRAMES_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = kei_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  kei_stream_if.sink    req_i,
  kei_stream_if.source  rsp_o,
  kei_stream_if.sink    cfg_i
);

  localparam int unsigned AW  = $clog2(MAX_KEYFRAMES);
  localparam int unsigned CW  = $clog2(MAX_KEYFRAMES + 1);
  localparam int unsigned QW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned NW  = 34 + $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DCW = $clog2(QW);

  localparam logic [QW-1:0] DEPTH_W = QW'(SINE_TABLE_DEPTH);
  localparam logic [CW-1:0] MAX_W   = CW'(MAX_KEYFRAMES);

  typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH+1];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] ent;
    for (int unsigned j = 0; j <= SINE_TABLE_DEPTH; j++) begin
      x    = (kei_pkg::HALF_PI_Q30 * 64'(j)) / SINE_TABLE_DEPTH;
      term = x;
      sum  = x;
      for (int unsigned k = 0; k < 8; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / kei_pkg::SERIES_DIV[k];
        if ((k % 2) == 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      ent    = (sum + 64'd16384) >> 15;
      rom[j] = ent[15:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_INS_RD   = 14'b00000000000010,
    ST_INS_WR   = 14'b00000000000100,
    ST_INS_PUT  = 14'b00000000001000,
    ST_Q_RD     = 14'b00000000010000,
    ST_Q_MUL    = 14'b00000000100000,
    ST_Q_EV     = 14'b00000001000000,
    ST_Q_PREP   = 14'b00000010000000,
    ST_DIV_SET  = 14'b00000100000000,
    ST_DIV      = 14'b00001000000000,
    ST_SIN_RD   = 14'b00010000000000,
    ST_EASE_MUL = 14'b00100000000000,
    ST_EASE_FIN = 14'b01000000000000,
    ST_FIN      = 14'b10000000000000
  } state_e;

  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_LAST  = 3'b010,
    PH_SCAN  = 3'b100
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [CW-1:0]        count_q, count_d;
  logic [15:0]          scale_q;
  logic                 rsp_valid_q;
  kei_pkg::rsp_t        rsp_q;

  logic [AW-1:0]        addr_q, addr_d;
  logic [AW-1:0]        ins_i_q, ins_i_d;
  kei_pkg::kf_t         key_q, key_d;
  logic [31:0]          q256_q, q256_d;
  logic [31:0]          sc_q, sc_d;
  logic [31:0]          lo_sc_q, lo_sc_d;
  logic [31:0]          hi_sc_q, hi_sc_d;
  logic signed [15:0]   lo_val_q, lo_val_d;
  logic signed [15:0]   hi_val_q, hi_val_d;
  logic                 have_hi_q, have_hi_d;
  logic signed [16:0]   c_q, c_d;
  logic [31:0]          d_q, d_d;
  logic [31:0]          t_q, t_d;
  logic [NW-1:0]        rem_q, rem_d;
  logic [NW-1:0]        dsh_q, dsh_d;
  logic [QW-1:0]        quo_q, quo_d;
  logic [DCW-1:0]       dc_q, dc_d;
  logic [31:0]          mag_q, mag_d;
  logic signed [15:0]   res_val_q, res_val_d;
  logic [1:0]           res_st_q, res_st_d;

  kei_pkg::kf_t         mem [MAX_KEYFRAMES];
  kei_pkg::kf_t         rd_q;
  logic                 we;
  logic [AW-1:0]        wa;
  kei_pkg::kf_t         wd;

  logic [15:0]          sin_q;
  logic [QW-1:0]        idx_c;
  logic [QW-1:0]        rom_addr;

  logic                 req_acc;
  logic [CW-1:0]        last_w;
  logic [CW+6:0]        cnt_ext;
  logic [16:0]          cmag17;
  logic [15:0]          w_c;
  logic [32:0]          rnd_c;
  logic signed [17:0]   ease_c;
  logic                 rising;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  assign last_w  = count_q - CW'(1);
  assign cnt_ext = {7'd0, count_q};

  assign rising   = !c_q[16];
  assign idx_c    = (quo_q > DEPTH_W) ? DEPTH_W : quo_q;
  assign rom_addr = rising ? (DEPTH_W - idx_c) : idx_c;
  assign cmag17   = c_q[16] ? 17'(-c_q) : 17'(c_q);
  assign w_c      = rising ? (16'd32768 - sin_q) : sin_q;
  assign rnd_c    = {1'b0, mag_q} + 33'd16384;
  assign ease_c   = rising ? (18'(lo_val_q) + $signed({1'b0, rnd_c[31:15]}))
                           : (18'(lo_val_q) - $signed({1'b0, rnd_c[31:15]}));

  // keyframe memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[addr_q];
  end

  // quarter-wave sine table
  always_ff @(posedge clk_i) begin
    sin_q <= SINE_ROM[rom_addr];
  end

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    count_d   = count_q;
    addr_d    = addr_q;
    ins_i_d   = ins_i_q;
    key_d     = key_q;
    q256_d    = q256_q;
    sc_d      = sc_q;
    lo_sc_d   = lo_sc_q;
    hi_sc_d   = hi_sc_q;
    lo_val_d  = lo_val_q;
    hi_val_d  = hi_val_q;
    have_hi_d = have_hi_q;
    c_d       = c_q;
    d_d       = d_q;
    t_d       = t_q;
    rem_d     = rem_q;
    dsh_d     = dsh_q;
    quo_d     = quo_q;
    dc_d      = dc_q;
    mag_d     = mag_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    we        = 1'b0;
    wa        = ins_i_q;
    wd        = rd_q;

    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          res_val_d = '0;
          res_st_d  = kei_pkg::STATUS_OK;
          key_d.pos = req_i.data.key_position;
          key_d.val = req_i.data.key_value;
          q256_d    = {req_i.data.query_position, 8'd0};
          state_d   = ST_FIN;
          case (req_i.data.command)
            kei_pkg::CMD_INSERT: begin
              if (count_q >= MAX_W) begin
                res_st_d = kei_pkg::STATUS_FULL;
              end else if (count_q == '0) begin
                ins_i_d = '0;
                state_d = ST_INS_PUT;
              end else begin
                ins_i_d = count_q[AW-1:0];
                addr_d  = last_w[AW-1:0];
                state_d = ST_INS_RD;
              end
            end
            kei_pkg::CMD_QUERY: begin
              if (count_q == '0) begin
                res_st_d = kei_pkg::STATUS_EMPTY;
              end else begin
                addr_d  = '0;
                phase_d = PH_FIRST;
                state_d = ST_Q_RD;
              end
            end
            kei_pkg::CMD_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_INS_RD: begin
        state_d = ST_INS_WR;
      end
      ST_INS_WR: begin
        if (rd_q.pos > key_q.pos) begin
          we = 1'b1;
          if (ins_i_q == AW'(1)) begin
            ins_i_d = '0;
            state_d = ST_INS_PUT;
          end else begin
            ins_i_d = ins_i_q - AW'(1);
            addr_d  = addr_q - AW'(1);
            state_d = ST_INS_RD;
          end
        end else begin
          state_d = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        we      = 1'b1;
        wd      = key_q;
        count_d = count_q + CW'(1);
        state_d = ST_FIN;
      end
      ST_Q_RD: begin
        state_d = ST_Q_MUL;
      end
      ST_Q_MUL: begin
        sc_d    = rd_q.pos * scale_q;
        state_d = ST_Q_EV;
      end
      ST_Q_EV: begin
        case (phase_q)
          PH_FIRST: begin
            if (q256_q <= sc_q) begin
              res_val_d = rd_q.val;
              state_d   = ST_FIN;
            end else begin
              addr_d  = last_w[AW-1:0];
              phase_d = PH_LAST;
              state_d = ST_Q_RD;
            end
          end
          PH_LAST: begin
            if (q256_q >= sc_q) begin
              res_val_d = rd_q.val;
              state_d   = ST_FIN;
            end else begin
              addr_d    = '0;
              have_hi_d = 1'b0;
              phase_d   = PH_SCAN;
              state_d   = ST_Q_RD;
            end
          end
          default: begin
            if (sc_q <= q256_q) begin
              lo_sc_d  = sc_q;
              lo_val_d = rd_q.val;
            end
            if (sc_q >= q256_q && (!have_hi_q || sc_q <= hi_sc_q)) begin
              hi_sc_d   = sc_q;
              hi_val_d  = rd_q.val;
              have_hi_d = 1'b1;
            end
            if (addr_q == last_w[AW-1:0]) begin
              state_d = ST_Q_PREP;
            end else begin
              addr_d  = addr_q + AW'(1);
              state_d = ST_Q_RD;
            end
          end
        endcase
      end
      ST_Q_PREP: begin
        c_d     = 17'(hi_val_q) - 17'(lo_val_q);
        d_d     = hi_sc_q - lo_sc_q;
        t_d     = q256_q - lo_sc_q;
        state_d = ST_DIV_SET;
      end
      ST_DIV_SET: begin
        if (d_q == '0 || c_q == '0) begin
          res_val_d = lo_val_q;
          state_d   = ST_FIN;
        end else begin
          rem_d   = NW'(t_q) * NW'(2 * SINE_TABLE_DEPTH) + NW'(d_q);
          dsh_d   = NW'({d_q, 1'b0}) << (QW - 1);
          quo_d   = '0;
          dc_d    = DCW'(QW - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_q >= dsh_q) begin
          rem_d = rem_q - dsh_q;
          quo_d = {quo_q[QW-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[QW-2:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
        if (dc_q == '0) begin
          state_d = ST_SIN_RD;
        end else begin
          dc_d = dc_q - DCW'(1);
        end
      end
      ST_SIN_RD: begin
        state_d = ST_EASE_MUL;
      end
      ST_EASE_MUL: begin
        mag_d   = cmag17[15:0] * w_c;
        state_d = ST_EASE_FIN;
      end
      ST_EASE_FIN: begin
        res_val_d = ease_c[15:0];
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST;
      count_q     <= '0;
      scale_q     <= kei_pkg::SCALE_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      count_q <= count_d;
      if (cfg_i.valid) begin
        scale_q <= cfg_i.data;
      end
      if (state_q == ST_FIN && (!rsp_valid_q || rsp_o.ready)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    ins_i_q   <= ins_i_d;
    key_q     <= key_d;
    q256_q    <= q256_d;
    sc_q      <= sc_d;
    lo_sc_q   <= lo_sc_d;
    hi_sc_q   <= hi_sc_d;
    lo_val_q  <= lo_val_d;
    hi_val_q  <= hi_val_d;
    have_hi_q <= have_hi_d;
    c_q       <= c_d;
    d_q       <= d_d;
    t_q       <= t_d;
    rem_q     <= rem_d;
    dsh_q     <= dsh_d;
    quo_q     <= quo_d;
    dc_q      <= dc_d;
    mag_q     <= mag_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    if (state_q == ST_FIN && (!rsp_valid_q || rsp_o.ready)) begin
      rsp_q.eased_value    <= res_val_q;
      rsp_q.status         <= res_st_q;
      rsp_q.keyframe_count <= cnt_ext[6:0];
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_W)
    else $error("keyframe count above table depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_PUT) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not add one keyframe");

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && dc_q == '0) |=> (quo_q <= DEPTH_W))
    else $error("sine index above table depth");

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.data.command == kei_pkg::CMD_QUERY && count_q != '0)
      |=> (state_q == ST_Q_RD && addr_q == '0))
    else $error("query did not start at the first entry");

  a_fin_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && state_d == ST_IDLE) |=> rsp_valid_q)
    else $error("finished request left no result");

endmodule

// ===== test/keyframe_envelope_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_envelope_interpolator_tb
// Drives inserts, queries, clears and undefined commands through the request
// channel under random idle gaps and back-pressure, sweeps the position scale
// register, and checks every result against a local model of the keyframe
// table and the sine-eased interpolation.
// ----------------------------------------------------------------------------
module keyframe_envelope_interpolator_tb;

  localparam int unsigned NKEYS      = kei_pkg::MAX_KEYFRAMES_DEF;
  localparam int unsigned SDEPTH     = kei_pkg::SINE_TABLE_DEPTH_DEF;
  localparam int unsigned STALL_MAX  = 20000;
  localparam int unsigned SETTLE     = 300;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  class envelope_scoreboard;
    logic [15:0]        key_pos [NKEYS];
    logic signed [15:0] key_val [NKEYS];
    int unsigned        key_count;
    logic [15:0]        scale;
    int unsigned        sine [SDEPTH + 1];
    kei_pkg::rsp_t      pending [$];
    int unsigned        errors;
    int unsigned        n_checked;
    int unsigned        n_full;
    int unsigned        n_empty;

    function new();
      longint unsigned x, term, sum;
      key_count = 0;
      scale = kei_pkg::SCALE_RESET;
      errors = 0;
      n_checked = 0;
      n_full = 0;
      n_empty = 0;
      for (int j = 0; j <= SDEPTH; j++) begin
        x = (kei_pkg::HALF_PI_Q30 * longint'(j)) / SDEPTH;
        term = x;
        sum = x;
        for (int k = 1; k <= 8; k++) begin
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / ((2 * k) * (2 * k + 1));
          if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
        sine[j] = int'((sum + 16384) >> 15);
      end
    endfunction

    function automatic logic [23:0] scaled_at(int unsigned idx);
      return 24'((longint'(key_pos[idx]) * scale) >> 8);
    endfunction

    function automatic int eased_at(logic [23:0] q);
      longint unsigned q256, s, t, d, idx, w, r, sc, sc_hi;
      int unsigned lo, hi, n;
      bit have_hi;
      int b, c;
      q256 = longint'(q) << 8;
      s = scale;
      n = key_count;
      lo = 0;
      hi = 0;
      have_hi = 0;
      if (q256 <= longint'(key_pos[0]) * s) return key_val[0];
      if (q256 >= longint'(key_pos[n - 1]) * s) return key_val[n - 1];
      for (int i = 0; i < n; i++) begin
        sc = longint'(key_pos[i]) * s;
        sc_hi = longint'(key_pos[hi]) * s;
        if (sc <= q256) lo = i;
        if (sc >= q256 && (!have_hi || sc <= sc_hi)) begin
          hi = i;
          have_hi = 1;
        end
      end
      b = key_val[lo];
      c = int'(key_val[hi]) - b;
      t = q256 - longint'(key_pos[lo]) * s;
      d = longint'(key_pos[hi]) * s - longint'(key_pos[lo]) * s;
      if (d == 0 || c == 0) return b;
      idx = (t * SDEPTH * 2 + d) / (2 * d);
      if (idx > SDEPTH) idx = SDEPTH;
      if (c > 0) begin
        w = 32768 - sine[SDEPTH - idx];
        r = (longint'(c) * w + 16384) >> 15;
        return b + int'(r);
      end
      w = sine[idx];
      r = (longint'(-c) * w + 16384) >> 15;
      return b - int'(r);
    endfunction

    function void note_request(kei_pkg::req_t rq);
      kei_pkg::rsp_t e;
      int unsigned at;
      e.eased_value = '0;
      e.status = kei_pkg::STATUS_OK;
      case (rq.command)
        kei_pkg::CMD_INSERT: begin
          if (key_count >= NKEYS) begin
            e.status = kei_pkg::STATUS_FULL;
            n_full++;
          end else begin
            at = key_count;
            for (int i = 0; i < key_count; i++) begin
              if (key_pos[i] > rq.key_position) begin
                at = i;
                break;
              end
            end
            for (int i = key_count; i > at; i--) begin
              key_pos[i] = key_pos[i - 1];
              key_val[i] = key_val[i - 1];
            end
            key_pos[at] = rq.key_position;
            key_val[at] = rq.key_value;
            key_count++;
          end
        end
        kei_pkg::CMD_QUERY: begin
          if (key_count == 0) begin
            e.status = kei_pkg::STATUS_EMPTY;
            n_empty++;
          end else begin
            e.eased_value = 16'(eased_at(rq.query_position));
          end
        end
        kei_pkg::CMD_CLEAR: key_count = 0;
        default: ;
      endcase
      e.keyframe_count = 7'(key_count);
      pending.insert(pending.size(), e);
    endfunction

    function void check_result(kei_pkg::rsp_t got);
      kei_pkg::rsp_t e;
      n_checked++;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.eased_value !== e.eased_value) begin
        $error("eased_value exp %0d got %0d", e.eased_value, got.eased_value);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status);
        errors++;
      end
      if (got.keyframe_count !== e.keyframe_count) begin
        $error("keyframe_count exp %0d got %0d", e.keyframe_count, got.keyframe_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  kei_stream_if #(.T(kei_pkg::req_t)) req_ch ();
  kei_stream_if #(.T(kei_pkg::rsp_t)) rsp_ch ();
  kei_stream_if #(.T(logic [15:0]))   cfg_ch ();

  keyframe_envelope_interpolator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  envelope_scoreboard envelope = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          rsp_hold;
  int unsigned quiet_cycles;
  int unsigned n_requests;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(negedge clk_i) begin
    if (!rst_ni || rsp_hold) rsp_ch.ready = 1'b0;
    else rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) envelope.check_result(rsp_ch.data);
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_request(kei_pkg::req_t rq);
    bit done;
    done = 0;
    while (!done) begin
      @(negedge clk_i);
      if ($urandom_range(99) < send_idle_pct) begin
        req_ch.valid = 1'b0;
      end else begin
        req_ch.valid = 1'b1;
        req_ch.data = rq;
        @(posedge clk_i);
        while (!req_ch.ready) @(posedge clk_i);
        envelope.note_request(rq);
        n_requests++;
        done = 1;
      end
    end
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [15:0] kp, logic [15:0] kv,
                          logic [23:0] qp);
    kei_pkg::req_t rq;
    rq.command = cmd;
    rq.key_position = kp;
    rq.key_value = kv;
    rq.query_position = qp;
    send_request(rq);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (envelope.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [15:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    envelope.scale = v;
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [23:0] pick_query();
    longint base;
    if (envelope.key_count > 0 && $urandom_range(99) < 80) begin
      base = envelope.scaled_at($urandom_range(envelope.key_count - 1));
      base = base + $urandom_range(2000) - 1000;
      if (base < 0) base = 0;
      if (base > 24'hFFFFFF) base = 24'hFFFFFF;
      return 24'(base);
    end
    return 24'($urandom);
  endfunction

  task automatic send_random(int unsigned insert_pct);
    int unsigned roll;
    logic [15:0] kp;
    roll = $urandom_range(99);
    kp = ($urandom_range(3) == 0) ? 16'($urandom_range(15)) : 16'($urandom);
    if (roll < insert_pct) begin
      send_cmd(kei_pkg::CMD_INSERT, kp, 16'($urandom), 24'($urandom));
    end else if (roll < 95) begin
      send_cmd(kei_pkg::CMD_QUERY, 16'($urandom), 16'($urandom), pick_query());
    end else if (roll < 98) begin
      send_cmd(kei_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 24'($urandom));
    end else begin
      send_cmd(CMD_UNUSED, 16'($urandom), 16'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    logic [15:0] scales [5];
    scales = '{16'd1, 16'd65535, 16'($urandom_range(2, 65534)), 16'd384,
               kei_pkg::SCALE_RESET};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rsp_hold = 0;
    n_requests = 0;
    @(posedge rst_ni);

    // directed: empty query, extremes, equal positions, all easing shapes
    send_cmd(kei_pkg::CMD_QUERY, 16'd0, 16'd0, 24'd0);
    send_cmd(kei_pkg::CMD_INSERT, 16'd300, 16'sh7FFF, 24'd0);
    send_cmd(kei_pkg::CMD_INSERT, 16'd100, 16'sh8000, 24'd0);
    send_cmd(kei_pkg::CMD_INSERT, 16'd200, 16'sd10, 24'd0);
    send_cmd(kei_pkg::CMD_INSERT, 16'd200, 16'sd500, 24'd0);
    send_cmd(kei_pkg::CMD_QUERY, 16'd0, 16'd0, 24'd0);
    send_cmd(kei_pkg::CMD_QUERY, 16'd0, 16'd0, 24'hFFFFFF);
    send_cmd(kei_pkg::CMD_QUERY, 16'd0, 16'd0, 24'd150);
    send_cmd(kei_pkg::CMD_QUERY, 16'd0, 16'd0, 24'd200);
    send_cmd(kei_pkg::CMD_QUERY, 16'd0, 16'd0, 24'd250);
    send_cmd(kei_pkg::CMD_INSERT, 16'd400, 16'sh8000, 24'd0);
    send_cmd(kei_pkg::CMD_INSERT, 16'd500, 16'sh8000, 24'd0);
    send_cmd(kei_pkg::CMD_QUERY, 16'd0, 16'd0, 24'd350);
    send_cmd(kei_pkg::CMD_QUERY, 16'd0, 16'd0, 24'd450);
    send_cmd(kei_pkg::CMD_INSERT, 16'hFFFF, 16'sh7FFF, 24'd0);
    send_cmd(kei_pkg::CMD_INSERT, 16'd0, 16'sd0, 24'd0);
    send_cmd(kei_pkg::CMD_QUERY, 16'd0, 16'd0, 24'd65000);
    send_cmd(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send_cmd(kei_pkg::CMD_CLEAR, 16'd0, 16'd0, 24'd0);
    send_cmd(kei_pkg::CMD_QUERY, 16'd0, 16'd0, 24'd300);

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 63 : 0;
      recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 28 : 0;
      if (ph == 1) begin
        send_cmd(kei_pkg::CMD_CLEAR, 16'd0, 16'd0, 24'd0);
        repeat (NKEYS + 4) send_random(100);
      end
      for (int n = 0; n < 156; n++) begin
        if (ph == 0 && n == 40) begin
          rsp_hold = 1;
          fork
            begin
              repeat (400) @(negedge clk_i);
              rsp_hold = 0;
            end
          join_none
        end
        if (ph == 2 && n == 80) begin
          wait_drained();
          send_cmd(kei_pkg::CMD_QUERY, 16'd0, 16'd0, pick_query());
        end
        send_random(47);
      end
      write_scale(scales[ph]);
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    $display("covered %0d requests and %0d results over five position scales",
             n_requests, envelope.n_checked);
    $display("dropped inserts on a full table: %0d, queries on an empty table: %0d",
             envelope.n_full, envelope.n_empty);
    if (envelope.errors == 0 && envelope.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
